// File: hdl/d2ds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package d2ds_pkg;

    localparam logic [63:0] FifthMax = 64'h3333333333333333;
    localparam logic [63:0] IndBits  = 64'hfff8000000000000;
    localparam logic [10:0] ExpOnes  = 11'h7ff;
    localparam int          ExpBias  = 1075;

    typedef enum logic [1:0] {
        CLASS_FINITE = 2'd0,
        CLASS_INF    = 2'd1,
        CLASS_IND    = 2'd2,
        CLASS_NAN    = 2'd3
    } value_class_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SHIFT,
        CMD_PREP5,
        CMD_DIV5,
        CMD_DIV5_END,
        CMD_DOWN,
        CMD_COUNT,
        CMD_DIVP_PREP,
        CMD_DIVP_STEP,
        CMD_DIVP_END,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic special;
        logic e2_pos;
        logic e2_neg;
        logic m_msb;
        logic div5_last;
        logic divp_last;
        logic count_done;
        logic need_div;
    } status_t;

    function automatic logic [63:0] pow10(input logic [4:0] n);
        logic [63:0] r;
        begin
            case (n)
                5'd0:    r = 64'd1;
                5'd1:    r = 64'd10;
                5'd2:    r = 64'd100;
                5'd3:    r = 64'd1000;
                5'd4:    r = 64'd10000;
                5'd5:    r = 64'd100000;
                5'd6:    r = 64'd1000000;
                5'd7:    r = 64'd10000000;
                5'd8:    r = 64'd100000000;
                5'd9:    r = 64'd1000000000;
                5'd10:   r = 64'd10000000000;
                5'd11:   r = 64'd100000000000;
                5'd12:   r = 64'd1000000000000;
                5'd13:   r = 64'd10000000000000;
                5'd14:   r = 64'd100000000000000;
                5'd15:   r = 64'd1000000000000000;
                5'd16:   r = 64'd10000000000000000;
                5'd17:   r = 64'd100000000000000000;
                5'd18:   r = 64'd1000000000000000000;
                5'd19:   r = 64'd10000000000000000000;
                default: r = 64'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/double_to_decimal_significand_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts the bit pattern of a binary64 value into sign, class, decimal significand
// and power-of-ten exponent. One request enters on in_valid/in_ready with double_bits;
// one result leaves on out_valid/out_ready with is_negative, value_class, significand
// and dec_exponent. Requests are processed one at a time.
// Zero, infinity and NaN patterns skip the arithmetic: after the load they go straight
// to the output step.
// A value with a negative binary exponent takes up to 1074 halving steps; then its
// digits are counted and, where it has more than SIG_DIGITS digits, it is rounded by
// a divide by a power of ten.
// A value with a positive binary exponent is doubled step by step; a doubling that
// would overflow becomes a divide-by-five step, and that divider retires 8 bits per
// cycle. The digit count and, where needed, the final divide follow.
// A new request is taken as soon as the previous one has been placed in the output
// register, even while that result is still waiting on out_ready. If the receiver
// stalls, the finished result is held in the core until the output register frees.
// Reset clears the controller and drops out_valid; no result is pending afterward.
module double_to_decimal_significand_core #(
    parameter int SIG_DIGITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [63:0]       double_bits,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   is_negative,
    output logic [1:0]             value_class,
    output logic [53:0]            significand,
    output logic signed [9:0]      dec_exponent
);

    d2ds_pkg::status_t st;
    d2ds_pkg::cmd_t    cmd;

    d2ds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    d2ds_dp #(
        .SIG_DIGITS (SIG_DIGITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .double_bits  (double_bits),
        .st           (st),
        .is_negative  (is_negative),
        .value_class  (value_class),
        .significand  (significand),
        .dec_exponent (dec_exponent)
    );

endmodule

`default_nettype wire

// File: hdl/d2ds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module d2ds_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire d2ds_pkg::status_t st,
    output d2ds_pkg::cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP,
        ST_DIV5,
        ST_DIV5_END,
        ST_DOWN,
        ST_COUNT,
        ST_DIVP,
        ST_DIVP_END,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = d2ds_pkg::CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = d2ds_pkg::CMD_LOAD;
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                if (st.special)
                begin
                    state_next = ST_FINISH;
                end
                else if (st.e2_pos)
                begin
                    if (st.m_msb)
                    begin
                        cmd        = d2ds_pkg::CMD_PREP5;
                        state_next = ST_DIV5;
                    end
                    else
                    begin
                        cmd = d2ds_pkg::CMD_SHIFT;
                    end
                end
                else if (st.e2_neg)
                begin
                    state_next = ST_DOWN;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_DIV5:
            begin
                cmd = d2ds_pkg::CMD_DIV5;
                if (st.div5_last)
                begin
                    state_next = ST_DIV5_END;
                end
            end
            ST_DIV5_END:
            begin
                cmd        = d2ds_pkg::CMD_DIV5_END;
                state_next = ST_UP;
            end
            ST_DOWN:
            begin
                if (st.e2_neg)
                begin
                    cmd = d2ds_pkg::CMD_DOWN;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (!st.count_done)
                begin
                    cmd = d2ds_pkg::CMD_COUNT;
                end
                else if (st.need_div)
                begin
                    cmd        = d2ds_pkg::CMD_DIVP_PREP;
                    state_next = ST_DIVP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVP:
            begin
                cmd = d2ds_pkg::CMD_DIVP_STEP;
                if (st.divp_last)
                begin
                    state_next = ST_DIVP_END;
                end
            end
            ST_DIVP_END:
            begin
                cmd        = d2ds_pkg::CMD_DIVP_END;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd        = d2ds_pkg::CMD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd == d2ds_pkg::CMD_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == d2ds_pkg::CMD_OUT) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after a request was taken");

    a_divp_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVP && st.divp_last) |=> (state_reg == ST_DIVP_END))
        else $error("power-of-ten divide did not finish on its last step");

endmodule

`default_nettype wire

// File: hdl/d2ds_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module d2ds_dp #(
    parameter int SIG_DIGITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire d2ds_pkg::cmd_t    cmd,
    input  wire logic [63:0]       double_bits,
    output d2ds_pkg::status_t      st,
    output logic                   is_negative,
    output logic [1:0]             value_class,
    output logic [53:0]            significand,
    output logic signed [9:0]      dec_exponent
);

    localparam logic [4:0] SigDigitsW = 5'(SIG_DIGITS);

    logic [63:0]        m_reg, m_next;
    logic signed [11:0] e2_reg, e2_next;
    logic signed [9:0]  e10_reg, e10_next;
    logic               neg_reg, neg_next;
    logic [1:0]         cls_reg, cls_next;
    logic               special_reg, special_next;
    logic [4:0]         d_reg, d_next;
    logic [4:0]         s_reg, s_next;
    logic [63:0]        b_reg, b_next;
    logic [63:0]        rem_reg, rem_next;
    logic [2:0]         r5_reg, r5_next;
    logic [5:0]         cnt_reg, cnt_next;

    logic               neg_out_reg;
    logic [1:0]         cls_out_reg;
    logic [53:0]        sig_out_reg;
    logic signed [9:0]  exp_out_reg;

    logic [10:0]        exp_field;
    logic               in_zero;
    logic               in_nonfinite;
    logic [1:0]         in_class;
    logic [2:0]         r5;
    logic [3:0]         t5;
    logic [7:0]         q8;
    logic [64:0]        tdiv;
    logic               count_more;
    logic [63:0]        pow_d;

    assign exp_field    = double_bits[62:52];
    assign in_zero      = (double_bits[62:0] == 63'd0);
    assign in_nonfinite = (exp_field == d2ds_pkg::ExpOnes);

    always_comb
    begin
        if (!in_nonfinite)
        begin
            in_class = d2ds_pkg::CLASS_FINITE;
        end
        else if (double_bits[51:0] == 52'd0)
        begin
            in_class = d2ds_pkg::CLASS_INF;
        end
        else if (double_bits == d2ds_pkg::IndBits)
        begin
            in_class = d2ds_pkg::CLASS_IND;
        end
        else
        begin
            in_class = d2ds_pkg::CLASS_NAN;
        end
    end

    always_comb
    begin
        r5 = r5_reg;
        q8 = 8'd0;
        t5 = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            t5 = {r5, m_reg[63 - i]};
            if (t5 >= 4'd5)
            begin
                q8[7 - i] = 1'b1;
                r5        = 3'(t5 - 4'd5);
            end
            else
            begin
                r5 = t5[2:0];
            end
        end
    end

    assign tdiv       = {rem_reg, m_reg[63]};
    assign pow_d      = d2ds_pkg::pow10(d_reg);
    assign count_more = (d_reg < 5'd20) && (m_reg >= pow_d);

    always_comb
    begin
        m_next       = m_reg;
        e2_next      = e2_reg;
        e10_next     = e10_reg;
        neg_next     = neg_reg;
        cls_next     = cls_reg;
        special_next = special_reg;
        d_next       = d_reg;
        s_next       = s_reg;
        b_next       = b_reg;
        rem_next     = rem_reg;
        r5_next      = r5_reg;
        cnt_next     = cnt_reg;
        unique case (cmd)
            d2ds_pkg::CMD_LOAD:
            begin
                neg_next     = double_bits[63];
                cls_next     = in_class;
                special_next = in_zero || in_nonfinite;
                e10_next     = 10'sd0;
                d_next       = 5'd1;
                if (in_zero)
                begin
                    m_next  = 64'd0;
                    e2_next = 12'sd0;
                end
                else if (in_nonfinite)
                begin
                    m_next  = 64'd1;
                    e2_next = 12'sd0;
                end
                else if (exp_field == 11'd0)
                begin
                    m_next  = {12'd0, double_bits[51:0]};
                    e2_next = 12'sd1 - 12'(d2ds_pkg::ExpBias);
                end
                else
                begin
                    m_next  = {11'd0, 1'b1, double_bits[51:0]};
                    e2_next = $signed({1'b0, exp_field}) - 12'(d2ds_pkg::ExpBias);
                end
            end
            d2ds_pkg::CMD_SHIFT:
            begin
                m_next  = {m_reg[62:0], 1'b0};
                e2_next = e2_reg - 12'sd1;
            end
            d2ds_pkg::CMD_PREP5:
            begin
                m_next   = m_reg - 64'd3;
                r5_next  = 3'd0;
                cnt_next = 6'd0;
            end
            d2ds_pkg::CMD_DIV5:
            begin
                m_next   = {m_reg[55:0], q8};
                r5_next  = r5;
                cnt_next = cnt_reg + 6'd1;
            end
            d2ds_pkg::CMD_DIV5_END:
            begin
                m_next   = m_reg + 64'd1;
                e10_next = e10_reg + 10'sd1;
                e2_next  = e2_reg - 12'sd1;
            end
            d2ds_pkg::CMD_DOWN:
            begin
                if (m_reg <= d2ds_pkg::FifthMax)
                begin
                    m_next   = {m_reg[61:0], 2'b00} + m_reg;
                    e10_next = e10_reg - 10'sd1;
                end
                else
                begin
                    m_next = {1'b0, m_reg[63:1]} + {63'd0, m_reg[1] & m_reg[0]};
                end
                e2_next = e2_reg + 12'sd1;
            end
            d2ds_pkg::CMD_COUNT:
            begin
                if (count_more)
                begin
                    d_next = d_reg + 5'd1;
                end
            end
            d2ds_pkg::CMD_DIVP_PREP:
            begin
                s_next   = d_reg - SigDigitsW;
                b_next   = d2ds_pkg::pow10(d_reg - SigDigitsW);
                rem_next = 64'd0;
                cnt_next = 6'd0;
            end
            d2ds_pkg::CMD_DIVP_STEP:
            begin
                if (tdiv >= {1'b0, b_reg})
                begin
                    rem_next = 64'(tdiv - {1'b0, b_reg});
                    m_next   = {m_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = tdiv[63:0];
                    m_next   = {m_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
            end
            d2ds_pkg::CMD_DIVP_END:
            begin
                if ({rem_reg, 1'b0} >= {1'b0, b_reg})
                begin
                    m_next = m_reg + 64'd1;
                end
                e10_next = e10_reg + $signed({5'd0, s_reg});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= 5'd1;
        end
        else
        begin
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        e2_reg      <= e2_next;
        e10_reg     <= e10_next;
        neg_reg     <= neg_next;
        cls_reg     <= cls_next;
        special_reg <= special_next;
        s_reg       <= s_next;
        b_reg       <= b_next;
        rem_reg     <= rem_next;
        r5_reg      <= r5_next;
        cnt_reg     <= cnt_next;
        if (cmd == d2ds_pkg::CMD_OUT)
        begin
            neg_out_reg <= neg_reg;
            cls_out_reg <= cls_reg;
            sig_out_reg <= m_reg[53:0];
            exp_out_reg <= e10_reg;
        end
    end

    assign st.special    = special_reg;
    assign st.e2_pos     = (e2_reg > 12'sd0);
    assign st.e2_neg     = (e2_reg < 12'sd0);
    assign st.m_msb      = m_reg[63];
    assign st.div5_last  = (cnt_reg[2:0] == 3'd7);
    assign st.divp_last  = (cnt_reg == 6'd63);
    assign st.count_done = !count_more;
    assign st.need_div   = (d_reg > SigDigitsW);

    assign is_negative  = neg_out_reg;
    assign value_class  = cls_out_reg;
    assign significand  = sig_out_reg;
    assign dec_exponent = exp_out_reg;

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        d_reg <= 5'd20)
        else $error("digit count ran past twenty");

    a_shift_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == d2ds_pkg::CMD_SHIFT) |-> !m_reg[63])
        else $error("doubling would drop the top bit");

    a_down_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == d2ds_pkg::CMD_DOWN) |-> (e2_reg < 12'sd0))
        else $error("halving step issued with a non-negative binary exponent");

endmodule

`default_nettype wire

// File: tb/d2ds_conversion_check.sv
`timescale 1ns / 1ps

module d2ds_conversion_check #(
    parameter int SIG_DIGITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [63:0]        double_bits,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               is_negative,
    input  logic [1:0]         value_class,
    input  logic [53:0]        significand,
    input  logic signed [9:0]  dec_exponent,
    output int                 failures,
    output int                 outstanding
);

    typedef struct packed {
        logic                   negative;
        d2ds_pkg::value_class_t vclass;
        logic [53:0]            digits;
        logic [9:0]             exp10;
    } decimal_result_t;

    typedef struct packed {
        logic [63:0]     source;
        decimal_result_t result;
    } pending_conversion_t;

    pending_conversion_t conversions_q[$];

    function automatic logic [63:0] ten_power(input int n);
        logic [63:0] r;
        int i;
        r = 64'd1;
        for (i = 0; i < n && i < 19; i++)
        begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    function automatic decimal_result_t convert_double(input logic [63:0] bits);
        decimal_result_t r;
        logic [63:0] m;
        logic [63:0] unit;
        logic [63:0] q;
        int e2;
        int e10;
        int nd;
        int excess;
        r.negative = bits[63];
        r.vclass = d2ds_pkg::CLASS_FINITE;
        r.digits = 54'd1;
        r.exp10 = '0;
        if (bits[62:0] == 63'd0)
        begin
            r.digits = 54'd0;
        end
        else if (bits[62:52] != d2ds_pkg::ExpOnes)
        begin
            m = {12'd0, bits[51:0]};
            e2 = int'(bits[62:52]);
            e2 = e2 - 1023;
            e10 = 0;
            if (e2 > -1023)
            begin
                m[52] = 1'b1;
            end
            else
            begin
                e2 = e2 + 1;
            end
            e2 = e2 - 52;
            // A doubling that would overflow becomes a divide by five.
            while (e2 > 0)
            begin
                if (!m[63])
                begin
                    m = m << 1;
                end
                else
                begin
                    m = (m - 64'd3) / 64'd5 + 64'd1;
                    e10++;
                end
                e2--;
            end
            // A halving is a multiply by five where it fits, else it rounds to even.
            while (e2 < 0)
            begin
                if (m <= d2ds_pkg::FifthMax)
                begin
                    m = m * 64'd5;
                    e10--;
                end
                else
                begin
                    m = (m >> 1) + {63'd0, m[0] & m[1]};
                end
                e2++;
            end
            nd = 1;
            while (nd < 20 && m >= ten_power(nd))
            begin
                nd++;
            end
            if (nd > SIG_DIGITS)
            begin
                excess = nd - SIG_DIGITS;
                unit = ten_power(excess);
                q = m / unit;
                if ((m % unit) >= (unit + 64'd1) / 64'd2)
                begin
                    q = q + 64'd1;
                end
                m = q;
                e10 = e10 + excess;
            end
            r.digits = m[53:0];
            r.exp10 = e10[9:0];
        end
        else if (bits[51:0] == 52'd0)
        begin
            r.vclass = d2ds_pkg::CLASS_INF;
        end
        else if (bits == d2ds_pkg::IndBits)
        begin
            r.vclass = d2ds_pkg::CLASS_IND;
        end
        else
        begin
            r.vclass = d2ds_pkg::CLASS_NAN;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        pending_conversion_t want;
        decimal_result_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.negative = is_negative;
                seen.vclass = d2ds_pkg::value_class_t'(value_class);
                seen.digits = significand;
                seen.exp10 = dec_exponent;
                if (conversions_q.size() == 0)
                begin
                    if (failures < 10)
                    begin
                        $display("%0t: unexpected result neg=%0d class=%0d",
                                 $realtime, seen.negative, seen.vclass);
                        $display("    sig=%0d exp=%0d",
                                 seen.digits, $signed(seen.exp10));
                    end
                    failures++;
                end
                else
                begin
                    want = conversions_q.pop_front();
                    if (seen.negative !== want.result.negative
                        || seen.vclass !== want.result.vclass
                        || seen.digits !== want.result.digits
                        || seen.exp10 !== want.result.exp10)
                    begin
                        if (failures < 10)
                        begin
                            $display("%0t: mismatch for %h:", $realtime, want.source);
                            $display("    expected neg=%0d class=%0d sig=%0d exp=%0d",
                                     want.result.negative, want.result.vclass,
                                     want.result.digits, $signed(want.result.exp10));
                            $display("    got neg=%0d class=%0d sig=%0d exp=%0d",
                                     seen.negative, seen.vclass, seen.digits,
                                     $signed(seen.exp10));
                        end
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want.source = double_bits;
                want.result = convert_double(double_bits);
                conversions_q.push_back(want);
            end
        end
        outstanding <= conversions_q.size();
    end

endmodule

// File: tb/tb_double_to_decimal_significand_core.sv
`timescale 1ns / 1ps

module tb_double_to_decimal_significand_core;

    localparam int SigDigits      = 16;
    localparam int CycleLimit     = 20000000;
    localparam int HoldCycles     = 3000;
    localparam int RandomPerPhase = 120;
    localparam int SettleCycles   = 4000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [63:0]       double_bits = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              is_negative;
    logic [1:0]        value_class;
    logic [53:0]       significand;
    logic signed [9:0] dec_exponent;

    int failures;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    double_to_decimal_significand_core #(
        .SIG_DIGITS(SigDigits)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .double_bits(double_bits),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_negative(is_negative),
        .value_class(value_class),
        .significand(significand),
        .dec_exponent(dec_exponent)
    );

    d2ds_conversion_check #(
        .SIG_DIGITS(SigDigits)
    ) conversion_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .double_bits(double_bits),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_negative(is_negative),
        .value_class(value_class),
        .significand(significand),
        .dec_exponent(dec_exponent),
        .failures(failures),
        .outstanding(outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("double_to_decimal_significand_core verification failed");
            $finish;
        end
    end

    // Most values keep the binary exponent near the mantissa width, since the
    // conversion time grows with its distance; a share covers the whole range.
    function automatic logic [63:0] random_double(input logic quick);
        logic [63:0] frac;
        logic [10:0] ex;
        int pick;
        frac = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
        begin
            frac = frac >> $urandom_range(51);
        end
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            case ($urandom_range(3))
                0:
                begin
                    ex = 11'd0;
                    frac = '0;
                end
                1:
                begin
                    ex = d2ds_pkg::ExpOnes;
                    frac = '0;
                end
                2:
                begin
                    return d2ds_pkg::IndBits;
                end
                default:
                begin
                    ex = d2ds_pkg::ExpOnes;
                    if (frac[51:0] == 52'd0)
                    begin
                        frac = 64'd1;
                    end
                end
            endcase
        end
        else if (!quick && pick < 12)
        begin
            ex = 11'd0;
        end
        else if (!quick && pick < 22)
        begin
            ex = 11'($urandom_range(2046, 1));
        end
        else if (quick)
        begin
            ex = 11'($urandom_range(1090, 1060));
        end
        else
        begin
            ex = 11'($urandom_range(1150, 1000));
        end
        return {1'($urandom_range(1)), ex, frac[51:0]};
    endfunction

    task automatic send_double(input logic [63:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        double_bits <= value;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    initial
    begin
        logic [63:0] corner_values [0:22];
        int i;
        int phase;
        int n;
        corner_values = '{
            64'h0000000000000000, 64'h8000000000000000, 64'h7ff0000000000000,
            64'hfff0000000000000, 64'hfff8000000000000, 64'h7ff8000000000000,
            64'h7ff0000000000001, 64'hffffffffffffffff, 64'h7fffffffffffffff,
            64'h0000000000000001, 64'h800fffffffffffff, 64'h0010000000000000,
            64'h7fefffffffffffff, 64'hffefffffffffffff, 64'h3ff0000000000000,
            64'hbff0000000000000, 64'h4024000000000000, 64'h3fb999999999999a,
            64'h4340000000000000, 64'h433fffffffffffff, 64'h3fefffffffffffff,
            64'h44b52d02c7e14af6, 64'h4376345785d89fff
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < 23; i++)
        begin
            send_double(corner_values[i]);
        end
        drain_results();

        // The receiver holds off while requests keep coming, so the core fills up.
        hold_req <= hold_req + 1;
        for (i = 0; i < 12; i++)
        begin
            send_double(random_double(1'b1));
        end
        drain_results();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 73;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 73;
                end
                default:
                begin
                    idle_pct = 34;
                    stall_pct <= 34;
                end
            endcase
            for (n = 0; n < RandomPerPhase; n++)
            begin
                send_double(random_double(1'b0));
            end
            drain_results();
        end

        repeat (SettleCycles) @(posedge clk);
        if (failures == 0 && outstanding == 0)
        begin
            $display("double_to_decimal_significand_core verification clean");
        end
        else
        begin
            $display("double_to_decimal_significand_core verification failed");
        end
        $finish;
    end

endmodule
